@@ hw/rtl/ltfla_pkg.sv @@
package ltfla_pkg;

    // surface geometry
    localparam int SURFACE_SIZE = 256;
    localparam int NUM_LEVELS   = 4;

    // per-level stack depths
    localparam int DEPTH0    = 4;
    localparam int DEPTH1    = 16;
    localparam int DEPTH2    = 64;
    localparam int DEPTH3    = 1024;
    localparam int MAX_DEPTH = DEPTH3;

    // widths of counts, stack indexes and the shared tile memory
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int MEM_DEPTH = DEPTH0 + DEPTH1 + DEPTH2 + DEPTH3;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // base of each level's stack within the tile memory
    localparam int BASE0 = 0;
    localparam int BASE1 = BASE0 + DEPTH0;
    localparam int BASE2 = BASE1 + DEPTH1;
    localparam int BASE3 = BASE2 + DEPTH2;

    // tile edge per level, at least one
    localparam int EDGE0 = (SURFACE_SIZE / 4  > 0) ? SURFACE_SIZE / 4  : 1;
    localparam int EDGE1 = (SURFACE_SIZE / 8  > 0) ? SURFACE_SIZE / 8  : 1;
    localparam int EDGE2 = (SURFACE_SIZE / 16 > 0) ? SURFACE_SIZE / 16 : 1;
    localparam int EDGE3 = (SURFACE_SIZE / 64 > 0) ? SURFACE_SIZE / 64 : 1;
    localparam int BAND  = EDGE0;

    // tiles per grid row and their log2
    localparam int COLS0 = SURFACE_SIZE / EDGE0;
    localparam int COLS1 = SURFACE_SIZE / EDGE1;
    localparam int COLS2 = SURFACE_SIZE / EDGE2;
    localparam int COLS3 = SURFACE_SIZE / EDGE3;
    localparam int COLS_LOG2_0 = $clog2(COLS0);
    localparam int COLS_LOG2_1 = $clog2(COLS1);
    localparam int COLS_LOG2_2 = $clog2(COLS2);
    localparam int COLS_LOG2_3 = $clog2(COLS3);

    // width of the grid geometry arithmetic
    localparam int GEO_W = 16;

    // request and result codes
    localparam logic       MODE_ALLOC   = 1'b0;
    localparam logic       MODE_FREE    = 1'b1;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] LOD0 = 2'd0;
    localparam logic [1:0] LOD1 = 2'd1;
    localparam logic [1:0] LOD2 = 2'd2;
    localparam logic [1:0] LOD3 = 2'd3;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [6:0] dim;
    } t_tile;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

    function automatic logic [CNT_W-1:0] level_depth(input logic [1:0] lod);
        logic [CNT_W-1:0] d;
        case (lod)
            LOD0:    d = CNT_W'(DEPTH0);
            LOD1:    d = CNT_W'(DEPTH1);
            LOD2:    d = CNT_W'(DEPTH2);
            default: d = CNT_W'(DEPTH3);
        endcase
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] level_base(input logic [1:0] lod);
        logic [ADDR_W-1:0] b;
        case (lod)
            LOD0:    b = ADDR_W'(BASE0);
            LOD1:    b = ADDR_W'(BASE1);
            LOD2:    b = ADDR_W'(BASE2);
            default: b = ADDR_W'(BASE3);
        endcase
        return b;
    endfunction

    // tile held at a stack index straight after reset: row-major grid in its band
    function automatic t_tile grid_tile(input logic [1:0] lod, input logic [IDX_W-1:0] idx);
        logic [GEO_W-1:0] col;
        logic [GEO_W-1:0] row;
        logic [GEO_W-1:0] edge_len;
        logic [GEO_W-1:0] y_base;
        logic [GEO_W-1:0] xx;
        logic [GEO_W-1:0] yy;
        t_tile            t;
        case (lod)
            LOD0: begin
                col      = GEO_W'(idx) & GEO_W'(COLS0 - 1);
                row      = GEO_W'(idx) >> COLS_LOG2_0;
                edge_len = GEO_W'(EDGE0);
                y_base   = GEO_W'(0);
            end
            LOD1: begin
                col      = GEO_W'(idx) & GEO_W'(COLS1 - 1);
                row      = GEO_W'(idx) >> COLS_LOG2_1;
                edge_len = GEO_W'(EDGE1);
                y_base   = GEO_W'(BAND);
            end
            LOD2: begin
                col      = GEO_W'(idx) & GEO_W'(COLS2 - 1);
                row      = GEO_W'(idx) >> COLS_LOG2_2;
                edge_len = GEO_W'(EDGE2);
                y_base   = GEO_W'(2 * BAND);
            end
            default: begin
                col      = GEO_W'(idx) & GEO_W'(COLS3 - 1);
                row      = GEO_W'(idx) >> COLS_LOG2_3;
                edge_len = GEO_W'(EDGE3);
                y_base   = GEO_W'(3 * BAND);
            end
        endcase
        xx    = col * edge_len;
        yy    = row * edge_len + y_base;
        t.x   = xx[7:0];
        t.y   = yy[7:0];
        t.dim = edge_len[6:0];
        return t;
    endfunction

endpackage

@@ hw/rtl/ltfla_ctrl.sv @@
module ltfla_ctrl
    import ltfla_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_ready        = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
            end
            ST_LOOKUP: begin
                o_cmd.exec = 1'b1;
            end
            ST_RESULT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/ltfla_dpath.sv @@
module ltfla_dpath
    import ltfla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    output t_ctrl_sts  o_sts,
    input  logic       i_mode,
    input  logic [1:0] i_tile_lod,
    input  logic [7:0] i_tile_x,
    input  logic [7:0] i_tile_y,
    input  logic [6:0] i_tile_dim,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [1:0] o_out_lod,
    output logic [7:0] o_out_x,
    output logic [7:0] o_out_y,
    output logic [6:0] o_out_dim
);

    // latched request
    logic             r_mode;
    logic [1:0]       r_lod;
    t_tile            r_in_tile;

    // per-level fill count and lowest count reached since reset
    logic [CNT_W-1:0] r_count [NUM_LEVELS];
    logic [CNT_W-1:0] r_low   [NUM_LEVELS];

    // shared tile memory, one stack region per level
    t_tile            mem [MEM_DEPTH];
    t_tile            r_rdata;

    // outcome of the lookup
    logic [1:0]       r_res_status;
    logic             r_use_grid;
    t_tile            r_grid;

    // output register
    logic             r_ovalid;
    logic [1:0]       r_status;
    logic [1:0]       r_out_lod;
    t_tile            r_out_tile;

    logic [CNT_W-1:0] cur_n;
    logic [CNT_W-1:0] cur_low;
    logic [CNT_W-1:0] cur_depth;
    logic             is_empty;
    logic             is_full;
    logic [IDX_W-1:0] pop_idx;
    logic [IDX_W-1:0] acc_idx;
    logic [ADDR_W-1:0] mem_addr;
    logic             do_pop;
    logic             do_push;
    logic [1:0]       res_status;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode        <= i_mode;
            r_lod         <= i_tile_lod;
            r_in_tile.x   <= i_tile_x;
            r_in_tile.y   <= i_tile_y;
            r_in_tile.dim <= i_tile_dim;
        end
    end

    // stack pointer decode for the latched level
    always_comb begin
        cur_n     = r_count[r_lod];
        cur_low   = r_low[r_lod];
        cur_depth = level_depth(r_lod);
        is_empty  = (cur_n == '0);
        is_full   = (cur_n >= cur_depth);
        pop_idx   = cur_n[IDX_W-1:0] - IDX_W'(1);
        acc_idx   = (r_mode == MODE_FREE) ? cur_n[IDX_W-1:0] : pop_idx;
        mem_addr  = level_base(r_lod) + ADDR_W'(acc_idx);
        do_pop    = i_cmd.exec && (r_mode == MODE_ALLOC) && !is_empty;
        do_push   = i_cmd.exec && (r_mode == MODE_FREE) && !is_full;
        if (r_mode == MODE_FREE) begin
            res_status = is_full ? STATUS_FULL : STATUS_OK;
        end else begin
            res_status = is_empty ? STATUS_EMPTY : STATUS_OK;
        end
    end

    // counts and low-water marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_count[i] <= level_depth(2'(i));
                r_low[i]   <= level_depth(2'(i));
            end
        end else if (do_pop) begin
            r_count[r_lod] <= cur_n - CNT_W'(1);
            if (cur_low == cur_n) begin
                r_low[r_lod] <= cur_n - CNT_W'(1);
            end
        end else if (do_push) begin
            r_count[r_lod] <= cur_n + CNT_W'(1);
        end
    end

    // tile memory write
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[mem_addr] <= r_in_tile;
        end
    end

    // tile memory read, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // entries below the low-water mark are served from the generated reset grid
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= res_status;
            r_use_grid   <= (cur_low == cur_n);
            r_grid       <= grid_tile(r_lod, pop_idx);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= r_res_status;
            if (r_mode == MODE_ALLOC && r_res_status == STATUS_OK) begin
                r_out_lod  <= r_lod;
                r_out_tile <= r_use_grid ? r_grid : r_rdata;
            end else begin
                r_out_lod  <= '0;
                r_out_tile <= '0;
            end
        end
    end

    assign o_sts.out_free = !r_ovalid || i_ready;

    assign o_valid   = r_ovalid;
    assign o_status  = r_status;
    assign o_out_lod = r_out_lod;
    assign o_out_x   = r_out_tile.x;
    assign o_out_y   = r_out_tile.y;
    assign o_out_dim = r_out_tile.dim;

endmodule

@@ hw/rtl/lod_tile_free_list_allocator_top.sv @@
// Tile allocator for a square atlas with four detail levels, one LIFO free
// stack per level.
// Request channel (i_valid / o_ready): i_mode selects allocate or free,
// i_tile_lod the level; x, y and dim are only used when freeing a tile.
// Result channel (o_valid / i_ready): one beat per request with a status of
// ok, level empty (allocate) or stack full (free, push refused); a granted
// tile comes back with its level, origin and edge, all other fields are 0.
// Each request passes through the controller's capture, stack access and
// result steps around the single-port tile memory; o_ready is high only in
// the idle step, so the next request is taken only after the last one's result step.
// A finished result waits in the output register while the next request is
// already taken; the controller holds its result step while the output is
// still occupied, so a stalled receiver backs up into o_ready.
// Reset: synchronous, active low. All stacks come out full with their grids;
// the grid contents are generated on the fly below each level's low-water
// mark, so no memory clearing pass is needed and requests are taken at once.
module lod_tile_free_list_allocator_top
    import ltfla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic [1:0] i_tile_lod,
    input  logic [7:0] i_tile_x,
    input  logic [7:0] i_tile_y,
    input  logic [6:0] i_tile_dim,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [1:0] o_out_lod,
    output logic [7:0] o_out_x,
    output logic [7:0] o_out_y,
    output logic [6:0] o_out_dim
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // sequencer
    ltfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // stacks, counts and result register
    ltfla_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_mode     (i_mode),
        .i_tile_lod (i_tile_lod),
        .i_tile_x   (i_tile_x),
        .i_tile_y   (i_tile_y),
        .i_tile_dim (i_tile_dim),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_out_lod  (o_out_lod),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_dim  (o_out_dim)
    );

    // one request in flight: a taken beat drops ready next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while another is in flight");

    // result status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STATUS_OK || o_status == STATUS_EMPTY ||
                     o_status == STATUS_FULL))
        else $error("undefined result status");

    // refused requests carry no tile
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STATUS_OK |->
            o_out_lod == 2'd0 && o_out_x == 8'd0 && o_out_y == 8'd0 && o_out_dim == 7'd0)
        else $error("failed request returned tile fields");

    // result load only happens in the result step, never with a request capture
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.load_in, cmd.exec, cmd.load_out}) <= 1)
        else $error("controller issued overlapping commands");

endmodule

@@ tb/sv/lod_tile_free_list_allocator_top_tb.sv @@
`timescale 1ns / 100ps

module lod_tile_free_list_allocator_top_tb;
    import ltfla_pkg::*;

    localparam int DIRECTED_ITEMS = 21;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int LONG_HOLD      = 250;
    localparam int TAIL_CYCLES    = 20;
    localparam int TIMEOUT_NS     = 2_000_000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       mode;
        logic [1:0] lod;
        logic [7:0] x;
        logic [7:0] y;
        logic [6:0] dim;
    } t_tile_req;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] lod;
        logic [7:0] x;
        logic [7:0] y;
        logic [6:0] dim;
    } t_reply;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       o_ready;
    logic       i_mode     = 1'b0;
    logic [1:0] i_tile_lod = '0;
    logic [7:0] i_tile_x   = '0;
    logic [7:0] i_tile_y   = '0;
    logic [6:0] i_tile_dim = '0;
    logic       o_valid;
    logic       i_ready    = 1'b0;
    logic [1:0] o_status;
    logic [1:0] o_out_lod;
    logic [7:0] o_out_x;
    logic [7:0] o_out_y;
    logic [6:0] o_out_dim;

    lod_tile_free_list_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_tile_lod (i_tile_lod),
        .i_tile_x   (i_tile_x),
        .i_tile_y   (i_tile_y),
        .i_tile_dim (i_tile_dim),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_out_lod  (o_out_lod),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_dim  (o_out_dim)
    );

    // shadow of the free stacks, one per level
    t_tile       shelf [NUM_LEVELS][MAX_DEPTH];
    int unsigned level_count [NUM_LEVELS];

    // occupancy as the stimulus generator sees it, used only to steer it
    int unsigned plan_count [NUM_LEVELS];
    int          queued_total;

    t_tile_req backlog [$];
    t_reply    awaited_replies [$];

    int send_gap;
    int sent_count   = 0;
    int ready_wait;
    int replies_seen = 0;
    int mismatches   = 0;

    function automatic int unsigned depth_of(input logic [1:0] lod);
        case (lod)
            LOD0:    return DEPTH0;
            LOD1:    return DEPTH1;
            LOD2:    return DEPTH2;
            default: return DEPTH3;
        endcase
    endfunction

    function automatic int unsigned edge_of(input logic [1:0] lod);
        int unsigned e;
        case (lod)
            LOD0:    e = SURFACE_SIZE / 4;
            LOD1:    e = SURFACE_SIZE / 8;
            LOD2:    e = SURFACE_SIZE / 16;
            default: e = SURFACE_SIZE / 64;
        endcase
        return (e == 0) ? 1 : e;
    endfunction

    // stacks after reset: each level's grid row by row, last tile on top
    task automatic load_reset_grids();
        int unsigned band;
        int unsigned e;
        int unsigned n;
        band = edge_of(LOD0);
        for (int lod = 0; lod < NUM_LEVELS; lod++) begin
            e = edge_of(2'(lod));
            n = 0;
            for (int row = 0; row < band / e && n < depth_of(2'(lod)); row++) begin
                for (int col = 0; col < SURFACE_SIZE / e && n < depth_of(2'(lod)); col++) begin
                    shelf[lod][n].x   = 8'(col * e);
                    shelf[lod][n].y   = 8'(row * e + lod * band);
                    shelf[lod][n].dim = 7'(e);
                    n++;
                end
            end
            level_count[lod] = n;
        end
    endtask

    // pop or push one tile and work out the reply the block owes for it
    function automatic t_reply serve_request(input t_tile_req req);
        t_reply      rep;
        int unsigned n;
        rep = '0;
        n   = level_count[req.lod];
        if (req.mode == MODE_ALLOC) begin
            if (n == 0) begin
                rep.status = STATUS_EMPTY;
            end else begin
                n--;
                level_count[req.lod] = n;
                rep.status = STATUS_OK;
                rep.lod    = req.lod;
                rep.x      = shelf[req.lod][n].x;
                rep.y      = shelf[req.lod][n].y;
                rep.dim    = shelf[req.lod][n].dim;
            end
        end else begin
            if (n >= depth_of(req.lod)) begin
                rep.status = STATUS_FULL;
            end else begin
                shelf[req.lod][n].x   = req.x;
                shelf[req.lod][n].y   = req.y;
                shelf[req.lod][n].dim = req.dim;
                level_count[req.lod]  = n + 1;
                rep.status = STATUS_OK;
            end
        end
        return rep;
    endfunction

    task automatic queue_request(input logic mode, input logic [1:0] lod,
                                 input logic [7:0] x, input logic [7:0] y,
                                 input logic [6:0] dim);
        t_tile_req req;
        req = '{mode: mode, lod: lod, x: x, y: y, dim: dim};
        backlog.insert(backlog.size(), req);
        queued_total++;
        if (mode == MODE_ALLOC) begin
            if (plan_count[lod] > 0) plan_count[lod]--;
        end else begin
            if (plan_count[lod] < depth_of(lod)) plan_count[lod]++;
        end
    endtask

    // allocate carries junk in the ignored fields
    task automatic queue_alloc(input logic [1:0] lod);
        queue_request(MODE_ALLOC, lod, 8'($urandom), 8'($urandom), 7'($urandom));
    endtask

    // mostly a tile that fits the level's grid, otherwise arbitrary contents
    task automatic queue_free_guess(input logic [1:0] lod);
        int unsigned e;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [6:0]  dim;
        e = edge_of(lod);
        if ($urandom_range(0, 99) < 60) begin
            x   = 8'($urandom_range(0, SURFACE_SIZE / e - 1) * e);
            y   = 8'(lod * edge_of(LOD0) + $urandom_range(0, edge_of(LOD0) / e - 1) * e);
            dim = 7'(e);
        end else begin
            x   = 8'($urandom_range(0, 255));
            y   = 8'($urandom_range(0, 255));
            dim = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(1, 64))
                                              : 7'($urandom_range(0, 127));
        end
        queue_request(MODE_FREE, lod, x, y, dim);
    endtask

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // request driver: one beat per pending item, random gap before each
    always @(posedge i_clk) begin : drive_requests
        t_tile_req nxt;
        t_reply    rep;
        int        gap;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
            load_reset_grids();
        end else begin
            if (i_valid && o_ready) begin
                rep = serve_request({i_mode, i_tile_lod, i_tile_x, i_tile_y, i_tile_dim});
                awaited_replies.insert(awaited_replies.size(), rep);
                sent_count++;
                gap = (((sent_count / 100) % 4) == 1) ? 0 : $urandom_range(0, 4);
                if (gap == 0 && backlog.size() > 0) begin
                    nxt = backlog.pop_front();
                    i_mode     <= nxt.mode;
                    i_tile_lod <= nxt.lod;
                    i_tile_x   <= nxt.x;
                    i_tile_y   <= nxt.y;
                    i_tile_dim <= nxt.dim;
                end else begin
                    i_valid  <= 1'b0;
                    send_gap <= gap;
                end
            end else if (!i_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (backlog.size() > 0) begin
                    nxt = backlog.pop_front();
                    i_mode     <= nxt.mode;
                    i_tile_lod <= nxt.lod;
                    i_tile_x   <= nxt.x;
                    i_tile_y   <= nxt.y;
                    i_tile_dim <= nxt.dim;
                    i_valid    <= 1'b1;
                end
            end
        end
    end

    // reply monitor: check each beat, random back-pressure, two long holds
    always @(posedge i_clk) begin : collect_replies
        t_reply want;
        t_reply got;
        int     w;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_status, o_out_lod, o_out_x, o_out_y, o_out_dim};
                if (awaited_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"reply %0d with no request outstanding: ",
                                  "st=%0d lod=%0d x=%0d y=%0d dim=%0d"},
                                 replies_seen, got.status, got.lod, got.x, got.y, got.dim);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"reply %0d mismatch: ",
                                      "want st=%0d lod=%0d x=%0d y=%0d dim=%0d, ",
                                      "got st=%0d lod=%0d x=%0d y=%0d dim=%0d"},
                                     replies_seen, want.status, want.lod, want.x, want.y,
                                     want.dim, got.status, got.lod, got.x, got.y, got.dim);
                    end
                end
                replies_seen++;
                if (replies_seen == 300 || replies_seen == 900) begin
                    i_ready    <= 1'b0;
                    ready_wait <= LONG_HOLD;
                end else begin
                    w = (((replies_seen / 100) % 4) == 1) ? 0 : $urandom_range(0, 4);
                    if (w > 0) begin
                        i_ready    <= 1'b0;
                        ready_wait <= w;
                    end
                end
            end else if (!i_ready) begin
                if (ready_wait > 0) ready_wait <= ready_wait - 1;
                else i_ready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : run_allocator
        bit          heavy_alloc;
        int          focus;
        int          seg_len;
        int          empty_hits;
        logic [1:0]  lod;
        queued_total = 0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            plan_count[l] = depth_of(2'(l));
        end

        // every level starts full: frees are refused
        queue_request(MODE_FREE, LOD0, 8'hFF, 8'hFF, 7'h7F);
        queue_request(MODE_FREE, LOD1, 8'h00, 8'h00, 7'h00);
        queue_request(MODE_FREE, LOD2, 8'hA5, 8'h5A, 7'h40);
        queue_request(MODE_FREE, LOD3, 8'h12, 8'h34, 7'h01);
        // drain level 0 and allocate once from empty
        repeat (5) queue_alloc(LOD0);
        // freed tiles stored as given and returned last in first out
        queue_request(MODE_FREE, LOD0, 8'hFF, 8'hFF, 7'h7F);
        queue_request(MODE_FREE, LOD0, 8'h00, 8'h00, 7'h00);
        queue_alloc(LOD0);
        queue_alloc(LOD0);
        queue_alloc(LOD0);
        queue_request(MODE_FREE, LOD0, 8'hAA, 8'h55, 7'h2A);
        queue_request(MODE_FREE, LOD0, 8'h55, 8'hAA, 7'h55);
        queue_alloc(LOD1);
        queue_alloc(LOD2);
        queue_alloc(LOD3);
        // refill level 3 to the brim, then overflow it
        queue_request(MODE_FREE, LOD3, 8'h80, 8'h01, 7'h04);
        queue_request(MODE_FREE, LOD3, 8'h01, 8'h80, 7'h04);

        // long stretch that empties level 3, with a sprinkling of other traffic
        empty_hits = 0;
        while (!(plan_count[3] == 0 && empty_hits >= 6)) begin
            if ($urandom_range(0, 99) < 90) begin
                if ($urandom_range(0, 99) < 97) begin
                    if (plan_count[3] == 0) empty_hits++;
                    queue_alloc(LOD3);
                end else begin
                    queue_free_guess(LOD3);
                end
            end else begin
                lod = 2'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 0) queue_alloc(lod);
                else queue_free_guess(lod);
            end
        end

        // segments that push one level towards empty or full
        while (queued_total < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            focus       = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
            heavy_alloc = $urandom_range(0, 1);
            seg_len     = $urandom_range(5, 40);
            repeat (seg_len) begin
                lod = ($urandom_range(0, 99) < 85) ? 2'(focus) : 2'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < (heavy_alloc ? 85 : 15)) queue_alloc(lod);
                else queue_free_guess(lod);
            end
        end

        // synchronous reset, then release
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all beats sent and all replies back, then a short tail
        while (backlog.size() > 0 || i_valid || awaited_replies.size() > 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ lod_tile_free_list_allocator_top.f @@
hw/rtl/ltfla_pkg.sv
hw/rtl/ltfla_ctrl.sv
hw/rtl/ltfla_dpath.sv
hw/rtl/lod_tile_free_list_allocator_top.sv
tb/sv/lod_tile_free_list_allocator_top_tb.sv
